// File: sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted-array priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEFAULT_CAPACITY = 16;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef struct packed {
    logic               op;
    logic signed [31:0] key_in;
    logic        [15:0] tag_in;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] key_out;
    logic        [15:0] tag_out;
    logic        [4:0]  count_out;
    logic               is_empty;
    logic               is_full;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
  } ctl_t;

endpackage

// File: sv/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: accepts one item, runs the datapath update, strobes the result.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  output spq_pkg::ctl_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy     = (state != S_IDLE);
  assign done     = (state == S_DONE);
  assign ctl.load = (state == S_IDLE) && start;
  assign ctl.exec = (state == S_EXEC);

endmodule

// File: sv/spq_datapath.sv
// ----------------------------------------------------------------------------
// spq_datapath
// Row of key/tag cells kept in ascending order; every cell picks its next
// value in parallel for an insert or a remove.
// ----------------------------------------------------------------------------
module spq_datapath #(
  parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
  input  logic          clk,
  input  logic          rst,
  input  spq_pkg::ctl_t ctl,
  input  spq_pkg::req_t req,
  output spq_pkg::rsp_t rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  spq_pkg::req_t      req_r;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic signed [31:0] key_store [CAPACITY];
  logic        [15:0] tag_store [CAPACITY];
  logic signed [31:0] key_ins   [CAPACITY];
  logic        [15:0] tag_ins   [CAPACITY];
  logic               le        [CAPACITY];
  logic               is_ins;
  logic               ins_ok;
  logic               rem_ok;
  logic [CNT_W+4:0]   count_wide;

  assign is_ins = (req_r.op == spq_pkg::OP_INSERT);
  assign ins_ok = is_ins && (count < CNT_W'(CAPACITY));
  assign rem_ok = !is_ins && (count != '0);

  // Cell i holds a key no larger than the new one: it keeps its place.
  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      assign le[g] = (CNT_W'(g) < count) && (key_store[g] <= req_r.key_in);
      if (g == 0) begin : g_head
        always_comb begin
          if (le[g]) begin
            key_ins[g] = key_store[g];
            tag_ins[g] = tag_store[g];
          end else begin
            key_ins[g] = req_r.key_in;
            tag_ins[g] = req_r.tag_in;
          end
        end
      end else begin : g_body
        always_comb begin
          if (le[g]) begin
            key_ins[g] = key_store[g];
            tag_ins[g] = tag_store[g];
          end else if (le[g-1]) begin
            key_ins[g] = req_r.key_in;
            tag_ins[g] = req_r.tag_in;
          end else begin
            key_ins[g] = key_store[g-1];
            tag_ins[g] = tag_store[g-1];
          end
        end
      end
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (ins_ok) count_next = count + CNT_W'(1);
    else if (rem_ok) count_next = count - CNT_W'(1);
  end

  assign count_wide = (CNT_W + 5)'(count_next);

  always_ff @(posedge clk) begin
    if (ctl.load) req_r <= req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.exec) begin
      count <= count_next;
    end
  end

  // Advance the cells: shift back behind the new key, or forward on remove.
  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      if (ins_ok) begin
        for (int i = 0; i < CAPACITY; i++) begin
          key_store[i] <= key_ins[i];
          tag_store[i] <= tag_ins[i];
        end
      end else if (rem_ok) begin
        for (int i = 0; i < CAPACITY - 1; i++) begin
          key_store[i] <= key_store[i+1];
          tag_store[i] <= tag_store[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      rsp.ok        <= ins_ok || rem_ok;
      rsp.key_out   <= rem_ok ? key_store[0] : '0;
      rsp.tag_out   <= rem_ok ? tag_store[0] : '0;
      rsp.count_out <= count_wide[4:0];
      rsp.is_empty  <= (count_next == '0);
      rsp.is_full   <= (count_next == CNT_W'(CAPACITY));
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    count >= CNT_W'(2) |-> key_store[0] <= key_store[1])
    else $error("head cells out of order");

  a_remove_count: assert property (@(posedge clk) disable iff (rst)
    ctl.exec && rem_ok |=> count == $past(count) - CNT_W'(1))
    else $error("remove did not drop the count");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    ctl.exec && !ins_ok && !rem_ok |=> !rsp.ok && rsp.key_out == '0 && rsp.tag_out == '0)
    else $error("refused item returned data");

endmodule

// File: sv/sorted_array_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_array_priority_queue_unit
// Minimum priority queue of key/tag pairs held as an ascending sorted array.
// ----------------------------------------------------------------------------
// Use: drive request (op, key_in, tag_in) and raise start while busy is low;
// the item is taken at that edge. op insert places the pair behind every
// stored pair with an equal or smaller signed key; op remove returns the
// smallest pair. Each item yields one result on the result port, valid for
// exactly one cycle while done is high: ok, removed key and tag (zero
// otherwise), entry count, empty and full flags. An insert on a full queue
// or a remove on an empty one returns ok low and changes nothing.
// Timing: after the accepting edge the controller passes through an update
// state, in which all cells compare and shift together, and a report state
// with done high; the result is registered at the edge on which done rises.
// Busy drops in the cycle after done, so a new item is taken only once the
// last one is through. The receiver cannot stall the result.
// Reset (rst, synchronous) empties the queue at once; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue_unit #(
  parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  spq_pkg::req_t request,
  output logic          done,
  output spq_pkg::rsp_t result
);

  spq_pkg::ctl_t ctl;

  spq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctl   (ctl)
  );

  spq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .req (request),
    .rsp (result)
  );

endmodule

// File: verif/tb_sorted_array_priority_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_array_priority_queue_unit
// Drives insert and remove items into the sorted-array priority queue and
// checks every result against a local model of the queue: a short directed
// run over key extremes, ties and the empty case, then random bursts that
// fill and drain the queue, with varying gaps on the command side.
// ----------------------------------------------------------------------------
module tb_sorted_array_priority_queue_unit;

  localparam int QCAP = spq_pkg::DEFAULT_CAPACITY;
  localparam int RANDOM_PER_PHASE = 430;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  spq_pkg::req_t request = '0;
  logic          busy;
  logic          done;
  spq_pkg::rsp_t result;

  // Local copy of the queue contents, ascending by signed key.
  logic signed [31:0] model_keys [QCAP];
  logic        [15:0] model_tags [QCAP];
  int                 model_count = 0;

  spq_pkg::req_t pending_requests [$];
  spq_pkg::rsp_t expected_results [$];
  int            sender_idle_pct = 0;
  int            error_count = 0;

  sorted_array_priority_queue_unit #(.CAPACITY(QCAP)) u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("sorted_array_priority_queue_unit test failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Apply one item to the local queue and return the result it should give.
  function automatic spq_pkg::rsp_t queue_apply(input spq_pkg::req_t item);
    spq_pkg::rsp_t res;
    int            pos;
    res = '0;
    if (item.op == spq_pkg::OP_INSERT) begin
      if (model_count < QCAP) begin
        pos = model_count;
        // shift strictly larger keys back so ties keep arrival order
        while (pos > 0 && $signed(model_keys[pos-1]) > $signed(item.key_in)) begin
          model_keys[pos] = model_keys[pos-1];
          model_tags[pos] = model_tags[pos-1];
          pos--;
        end
        model_keys[pos] = item.key_in;
        model_tags[pos] = item.tag_in;
        model_count++;
        res.ok = 1'b1;
      end
    end else begin
      if (model_count > 0) begin
        res.key_out = model_keys[0];
        res.tag_out = model_tags[0];
        for (int i = 1; i < model_count; i++) begin
          model_keys[i-1] = model_keys[i];
          model_tags[i-1] = model_tags[i];
        end
        model_count--;
        res.ok = 1'b1;
      end
    end
    res.count_out = model_count[4:0];
    res.is_empty  = (model_count == 0);
    res.is_full   = (model_count == QCAP);
    return res;
  endfunction

  // Driver: predict on acceptance, then offer the next pending item.
  always @(posedge clk) begin
    if (rst) begin
      start   <= 1'b0;
      request <= '0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(queue_apply(request));
        void'(pending_requests.pop_front());
      end
      if (pending_requests.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        start   <= 1'b1;
        request <= pending_requests[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest expectation.
  always @(posedge clk) begin
    spq_pkg::rsp_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, count", 32'(result.count_out), 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (result.ok !== want.ok)
          report_mismatch("ok", 32'(result.ok), 32'(want.ok));
        if (result.key_out !== want.key_out)
          report_mismatch("key_out", result.key_out, want.key_out);
        if (result.tag_out !== want.tag_out)
          report_mismatch("tag_out", 32'(result.tag_out), 32'(want.tag_out));
        if (result.count_out !== want.count_out)
          report_mismatch("count_out", 32'(result.count_out), 32'(want.count_out));
        if (result.is_empty !== want.is_empty)
          report_mismatch("is_empty", 32'(result.is_empty), 32'(want.is_empty));
        if (result.is_full !== want.is_full)
          report_mismatch("is_full", 32'(result.is_full), 32'(want.is_full));
      end
    end
  end

  task automatic push_item(input logic op, input logic [31:0] key, input logic [15:0] tag);
    spq_pkg::req_t item;
    item.op     = op;
    item.key_in = key;
    item.tag_in = tag;
    pending_requests.push_back(item);
  endtask

  // Mix full-range keys with a narrow band (many ties) and the extremes.
  function automatic logic [31:0] pick_key();
    int band;
    band = int'($urandom_range(0, 6)) - 3;
    case ($urandom_range(0, 3))
      0: pick_key = $urandom();
      1: pick_key = band << 16;
      2: begin
        case ($urandom_range(0, 3))
          0: pick_key = 32'h8000_0000;
          1: pick_key = 32'h7FFF_FFFF;
          2: pick_key = 32'h0000_0000;
          default: pick_key = 32'hFFFF_FFFF;
        endcase
      end
      default: pick_key = $urandom();
    endcase
  endfunction

  // Bursts of inserts run the queue into full, bursts of removes drain it; other bursts mix the two.
  task automatic push_random(input int n);
    int  added;
    int  mode;
    int  len;
    logic op;
    added = 0;
    while (added < n) begin
      mode = $urandom_range(0, 9);
      len  = $urandom_range(1, 20);
      for (int i = 0; i < len && added < n; i++) begin
        if (mode < 4)      op = spq_pkg::OP_INSERT;
        else if (mode < 7) op = spq_pkg::OP_REMOVE;
        else               op = $urandom_range(0, 1) ? spq_pkg::OP_REMOVE : spq_pkg::OP_INSERT;
        push_item(op, pick_key(), 16'($urandom_range(0, 65535)));
        added++;
      end
    end
  endtask

  task automatic drain_phase();
    while (pending_requests.size() > 0 || expected_results.size() > 0)
      @(negedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: remove on empty, key extremes, ties at min, max and mid
    sender_idle_pct = 10;
    push_item(spq_pkg::OP_REMOVE, 32'h0000_0000, 16'h0000);
    push_item(spq_pkg::OP_INSERT, 32'h7FFF_FFFF, 16'hFFFF);
    push_item(spq_pkg::OP_INSERT, 32'h8000_0000, 16'h0000);
    push_item(spq_pkg::OP_INSERT, 32'h0000_0000, 16'h0001);
    push_item(spq_pkg::OP_INSERT, 32'hFFFF_FFFF, 16'h0002);
    push_item(spq_pkg::OP_INSERT, 32'h0001_0000, 16'h0003);
    push_item(spq_pkg::OP_INSERT, 32'h0001_0000, 16'h0004);
    push_item(spq_pkg::OP_INSERT, 32'h0001_0000, 16'h0005);
    push_item(spq_pkg::OP_INSERT, 32'h8000_0000, 16'hAAAA);
    push_item(spq_pkg::OP_INSERT, 32'h7FFF_FFFF, 16'h5555);
    for (int i = 0; i < 10; i++)
      push_item(spq_pkg::OP_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
    push_random(RANDOM_PER_PHASE);
    drain_phase();

    sender_idle_pct = 50;
    push_random(RANDOM_PER_PHASE);
    drain_phase();

    sender_idle_pct = 0;
    push_random(RANDOM_PER_PHASE);
    drain_phase();

    // hold on to catch any stray result
    repeat (10) @(negedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("sorted_array_priority_queue_unit test passed");
    end else begin
      $display("sorted_array_priority_queue_unit test failed");
    end
    $finish;
  end

endmodule
